@@ hdl/osd_bitmap_overlay_i420_macros.svh @@
// ----------------------------------------------------------------------------
// osd bitmap overlay assertion macros
// shared concurrent check forms, clocked on clk with rst as disable
// ----------------------------------------------------------------------------
`ifndef OSD_BITMAP_OVERLAY_I420_MACROS_SVH
`define OSD_BITMAP_OVERLAY_I420_MACROS_SVH

// condition holds on every edge out of reset
`define OBO_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define OBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/obo_pkg.sv @@
// ----------------------------------------------------------------------------
// obo_pkg
// types, register codes and fixed-point constants of the osd bitmap overlay
// ----------------------------------------------------------------------------
package obo_pkg;

  localparam int DIM_W          = 13;
  localparam int POS_W          = 12;
  localparam int COLOR_W        = 8;
  localparam int MAX_FRAME_DIM  = 4096;
  localparam int COEF_FRAC_BITS = 16;
  localparam int ACC_W          = COEF_FRAC_BITS + 11;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;
  localparam int LUMA_ADDR_W    = 24;
  localparam int CHROMA_ADDR_W  = 25;
  localparam int PROD_W         = 2 * DIM_W;
  localparam int HALF_PROD_W    = 2 * (DIM_W - 1);

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_FRAME_DIM);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_R      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_G      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_B      = 3'd6;

  // q-format coefficients, rounded to nearest
  localparam longint unsigned QONE = longint'(1) << COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] COEF_Y_R = ACC_W'((299 * QONE + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_Y_G = ACC_W'((587 * QONE + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_Y_B = ACC_W'((114 * QONE + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_U_R = ACC_W'((1687 * QONE + 5000) / 10000);
  localparam logic signed [ACC_W-1:0] COEF_U_G = ACC_W'((3313 * QONE + 5000) / 10000);
  localparam logic signed [ACC_W-1:0] COEF_V_G = ACC_W'((4187 * QONE + 5000) / 10000);
  localparam logic signed [ACC_W-1:0] COEF_V_B = ACC_W'((813 * QONE + 5000) / 10000);
  localparam logic signed [ACC_W-1:0] COEF_HALF = ACC_W'(QONE / 2);
  localparam logic signed [ACC_W-1:0] CHROMA_BIAS = ACC_W'(128 * QONE);

  typedef struct packed {
    logic [POS_W-1:0]   glyph_row;
    logic [POS_W-1:0]   glyph_col;
    logic [COLOR_W-1:0] pixel_bit;
  } pixel_word_t;

  typedef struct packed {
    logic                     write_enable;
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic [CHROMA_ADDR_W-1:0] u_address;
    logic [CHROMA_ADDR_W-1:0] v_address;
    logic [COLOR_W-1:0]       luma_value;
    logic [COLOR_W-1:0]       u_value;
    logic [COLOR_W-1:0]       v_value;
  } result_word_t;

  // truncate toward zero and saturate to a byte
  function automatic logic [COLOR_W-1:0] to_byte(logic signed [ACC_W-1:0] acc);
    logic [ACC_W-COEF_FRAC_BITS-1:0] whole;
    whole = acc[ACC_W-1:COEF_FRAC_BITS];
    if (acc[ACC_W-1] || (acc == '0)) begin
      return '0;
    end else if (|whole[ACC_W-COEF_FRAC_BITS-1:COLOR_W]) begin
      return '1;
    end else begin
      return whole[COLOR_W-1:0];
    end
  endfunction

endpackage

@@ hdl/obo_ifs.sv @@
// ----------------------------------------------------------------------------
// obo channel interfaces
// bitmap word stream, result word stream and register write channel
// ----------------------------------------------------------------------------
interface obo_pixel_if;
  logic                 valid;
  logic                 ready;
  obo_pkg::pixel_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obo_result_if;
  logic                  valid;
  logic                  ready;
  obo_pkg::result_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obo_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [obo_pkg::CFG_IDX_W-1:0]      index;
  logic [obo_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/osd_bitmap_overlay_i420.sv @@
// ----------------------------------------------------------------------------
// osd_bitmap_overlay_i420: bitmap bit to i420 write address and color
// a word taken into the input register passes through combinational bounds,
// address and color logic into the result register, and is held there until taken
// throughput: one word per cycle, a stalled result side holds the input
// rst loads the configuration registers with their reset values and clears the valids
// ----------------------------------------------------------------------------
`include "osd_bitmap_overlay_i420_macros.svh"

module osd_bitmap_overlay_i420 (
  input  logic         clk,
  input  logic         rst,
  obo_pixel_if.sink    pixel,
  obo_result_if.source result,
  obo_cfg_if.sink      cfg
);

  typedef struct packed {
    logic                                  in_frame;
    logic [obo_pkg::DIM_W-1:0]             x;
    logic [obo_pkg::PROD_W-1:0]            luma_prod;
    logic [obo_pkg::HALF_PROD_W-1:0]       uv_prod;
    logic [obo_pkg::PROD_W-1:0]            plane;
    logic signed [obo_pkg::ACC_W-1:0]      ya;
    logic signed [obo_pkg::ACC_W-1:0]      ua;
    logic signed [obo_pkg::ACC_W-1:0]      va;
  } mid_t;

  // configuration registers
  logic [obo_pkg::DIM_W-1:0]   frame_width;
  logic [obo_pkg::DIM_W-1:0]   frame_height;
  logic [obo_pkg::POS_W-1:0]   origin_x;
  logic [obo_pkg::POS_W-1:0]   origin_y;
  logic [obo_pkg::COLOR_W-1:0] color_r;
  logic [obo_pkg::COLOR_W-1:0] color_g;
  logic [obo_pkg::COLOR_W-1:0] color_b;

  logic                  s1_valid, s3_valid;
  logic                  s1_ready, s3_ready;
  obo_pkg::pixel_word_t  s1;
  mid_t                  mid;
  obo_pkg::result_word_t s3, s3_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= obo_pkg::DIM_W'(640);
      frame_height <= obo_pkg::DIM_W'(480);
      origin_x     <= '0;
      origin_y     <= '0;
      color_r      <= '1;
      color_g      <= '1;
      color_b      <= '1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        obo_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data[obo_pkg::DIM_W-1:0];
        obo_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[obo_pkg::DIM_W-1:0];
        obo_pkg::REG_ORIGIN_X:     origin_x     <= cfg.data[obo_pkg::POS_W-1:0];
        obo_pkg::REG_ORIGIN_Y:     origin_y     <= cfg.data[obo_pkg::POS_W-1:0];
        obo_pkg::REG_COLOR_R:      color_r      <= cfg.data[obo_pkg::COLOR_W-1:0];
        obo_pkg::REG_COLOR_G:      color_g      <= cfg.data[obo_pkg::COLOR_W-1:0];
        obo_pkg::REG_COLOR_B:      color_b      <= cfg.data[obo_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage moves when empty or when the one after it moves
  assign s3_ready    = !s3_valid || result.ready;
  assign s1_ready    = !s1_valid || s3_ready;
  assign pixel.ready = s1_ready;

  // bounds, products and color accumulators
  logic [obo_pkg::DIM_W-1:0]        w_cl, h_cl, line_pos, x_pos;
  logic signed [obo_pkg::ACC_W-1:0] r_s, g_s, b_s;

  always_comb begin
    w_cl = (frame_width > obo_pkg::MAX_DIM) ? obo_pkg::MAX_DIM : frame_width;
    h_cl = (frame_height > obo_pkg::MAX_DIM) ? obo_pkg::MAX_DIM : frame_height;
    line_pos = {1'b0, origin_y} + {1'b0, s1.glyph_row};
    x_pos    = {1'b0, origin_x} + {1'b0, s1.glyph_col};
    r_s = $signed({{(obo_pkg::ACC_W-obo_pkg::COLOR_W){1'b0}}, color_r});
    g_s = $signed({{(obo_pkg::ACC_W-obo_pkg::COLOR_W){1'b0}}, color_g});
    b_s = $signed({{(obo_pkg::ACC_W-obo_pkg::COLOR_W){1'b0}}, color_b});

    mid.in_frame  = (s1.pixel_bit != '0) && (line_pos < h_cl) && (x_pos < w_cl);
    mid.x         = x_pos;
    mid.luma_prod = obo_pkg::PROD_W'(line_pos) * obo_pkg::PROD_W'(w_cl);
    mid.uv_prod   = obo_pkg::HALF_PROD_W'(line_pos[obo_pkg::DIM_W-1:1])
                    * obo_pkg::HALF_PROD_W'(w_cl[obo_pkg::DIM_W-1:1]);
    mid.plane     = obo_pkg::PROD_W'(w_cl) * obo_pkg::PROD_W'(h_cl);
    mid.ya = obo_pkg::COEF_Y_R * r_s + obo_pkg::COEF_Y_G * g_s
             + obo_pkg::COEF_Y_B * b_s;
    mid.ua = obo_pkg::CHROMA_BIAS - obo_pkg::COEF_U_R * r_s
             - obo_pkg::COEF_U_G * g_s + obo_pkg::COEF_HALF * b_s;
    mid.va = obo_pkg::CHROMA_BIAS + obo_pkg::COEF_HALF * r_s
             - obo_pkg::COEF_V_G * g_s - obo_pkg::COEF_V_B * b_s;
  end

  // address sums and byte saturation
  logic [obo_pkg::CHROMA_ADDR_W-1:0] uv_off;
  logic [obo_pkg::PROD_W:0]          v_sum;

  always_comb begin
    uv_off = obo_pkg::CHROMA_ADDR_W'(mid.uv_prod)
             + obo_pkg::CHROMA_ADDR_W'(mid.x[obo_pkg::DIM_W-1:1]);
    // v base is plane * 5 / 4 = plane + plane / 4
    v_sum  = (obo_pkg::PROD_W+1)'(mid.plane) + (obo_pkg::PROD_W+1)'(mid.plane >> 2)
             + (obo_pkg::PROD_W+1)'(uv_off);
    s3_next = '0;
    if (mid.in_frame) begin
      s3_next.write_enable = 1'b1;
      s3_next.luma_address = mid.luma_prod[obo_pkg::LUMA_ADDR_W-1:0]
                             + obo_pkg::LUMA_ADDR_W'(mid.x);
      s3_next.u_address    = mid.plane[obo_pkg::CHROMA_ADDR_W-1:0] + uv_off;
      s3_next.v_address    = v_sum[obo_pkg::CHROMA_ADDR_W-1:0];
      s3_next.luma_value   = obo_pkg::to_byte(mid.ya);
      s3_next.u_value      = obo_pkg::to_byte(mid.ua);
      s3_next.v_value      = obo_pkg::to_byte(mid.va);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pixel.valid;
      end
      if (s3_ready) begin
        s3_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pixel.valid) begin
      s1 <= pixel.data;
    end
    if (s3_ready && s1_valid) begin
      s3 <= s3_next;
    end
  end

  assign result.valid = s3_valid;
  assign result.data  = s3;

  `OBO_ASSERT_ALWAYS(a_dark_word_zero,
    !(s3_valid && !s3.write_enable) || (s3[$bits(s3)-2:0] == '0),
    "unwritten result word carries nonzero fields")
  `OBO_ASSERT_NEXT(a_word_moves, s1_valid && s3_ready, s3_valid,
    "word lost between input and result registers")
  `OBO_ASSERT_NEXT(a_outside_dark, s1_valid && s3_ready && !mid.in_frame,
    s3_valid && !s3.write_enable, "outside or unlit word marked for write")
  `OBO_ASSERT_NEXT(a_stall_holds_s3, s3_valid && !result.ready,
    s3_valid && $stable(s3), "stalled result word changed")

endmodule
